// File: rtl/core/i2cee_pkg.sv
// i2cee_pkg: shared types and constants of the i2c eeprom byte master
// phase encoding, request codes, register indexes and word field positions
// no dependencies
package i2cee_pkg;

    // bus half-period phases of one transaction
    typedef enum logic [3:0] {
        PH_IDLE        = 4'd0,
        PH_START_A     = 4'd1,
        PH_START_B     = 4'd2,
        PH_START_C     = 4'd3,
        PH_TX_LOW      = 4'd4,
        PH_TX_HIGH     = 4'd5,
        PH_ACK_LOW     = 4'd6,
        PH_ACK_POLL    = 4'd7,
        PH_RESTART_LOW = 4'd8,
        PH_RX_LOW      = 4'd9,
        PH_RX_HIGH     = 4'd10,
        PH_MNACK_LOW   = 4'd11,
        PH_MNACK_HIGH  = 4'd12,
        PH_STOP_A      = 4'd13,
        PH_STOP_B      = 4'd14,
        PH_STOP_C      = 4'd15
    } phase_t;

    // request codes carried in tuser
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // byte-sequence steps of a transaction
    localparam logic [1:0] SEQ_DEVICE  = 2'd0;
    localparam logic [1:0] SEQ_ADDRESS = 2'd1;
    localparam logic [1:0] SEQ_SECOND  = 2'd2;
    localparam logic [1:0] SEQ_RECEIVE = 2'd3;

    // register index, taken from paddr bit 2
    localparam logic REG_DEVICE_SELECT  = 1'b0;
    localparam logic REG_ACK_POLL_LIMIT = 1'b1;

    localparam logic [6:0] DEVICE_SELECT_RESET  = 7'd80;
    localparam logic [7:0] ACK_POLL_LIMIT_RESET = 8'd255;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // input word layout
    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned S_TUSER_W = 2;

    // result word layout
    localparam int unsigned M_TDATA_W    = 16;
    localparam int unsigned M_SCL_BIT    = 0;
    localparam int unsigned M_SDA_BIT    = 1;
    localparam int unsigned M_BUSY_BIT   = 2;
    localparam int unsigned M_DONE_BIT   = 3;
    localparam int unsigned M_RDATA_LSB  = 4;
    localparam int unsigned M_RDATA_MSB  = 11;
    localparam int unsigned M_NACK_BIT   = 12;

endpackage

// File: rtl/core/i2c_eeprom_byte_master_unit.sv
// i2c_eeprom_byte_master_unit: tick-driven i2c master for 24c02-style byte access
// depends on i2cee_pkg for phase type, request codes and word layout

// Each input word is one bus half-period: it carries the sampled SDA level and,
// while the master is idle, an optional byte-write or byte-read request in tuser.
// Each input word yields exactly one result word with the SCL and SDA drive levels,
// busy, done, the last read byte and the missing-acknowledge flag. The block takes
// one word per clock cycle unless the result side stalls, with one input and one
// result register around the single-pass tick logic. A stalled result register
// holds the input register, which drops s_axis_tready. Configuration writes go
// through the APB port while idle; the user ensures this, the block does not.
module i2c_eeprom_byte_master_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input words
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] word_address, [15:8] write_data, [16] sda_in, [23:17] zero
    input  logic [i2cee_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // [1:0] operation
    input  logic [i2cee_pkg::S_TUSER_W-1:0]     s_axis_tuser,
    // result words
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res,
    // [11:4] read_data, [12] ack_missing, [15:13] zero
    output logic [i2cee_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [i2cee_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [i2cee_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [i2cee_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);

    // configuration registers
    logic [6:0] device_select_reg;
    logic [7:0] ack_poll_limit_reg;

    // input register
    logic       in_valid_reg;
    logic [1:0] in_op_reg;
    logic [7:0] in_addr_reg;
    logic [7:0] in_data_reg;
    logic       in_sda_reg;

    // result register
    logic       out_valid_reg;
    logic       scl_reg, sda_reg, busy_reg, done_reg;

    // transaction state
    i2cee_pkg::phase_t phase_reg, phase_next;
    logic [1:0] seq_step_reg, seq_step_next;
    logic [2:0] bit_index_reg, bit_index_next;
    logic [7:0] shift_byte_reg, shift_byte_next;
    logic [7:0] poll_count_reg, poll_count_next;
    logic       is_read_reg, is_read_next;
    logic [7:0] latched_address_reg, latched_address_next;
    logic [7:0] latched_data_reg, latched_data_next;
    logic [7:0] read_result_reg, read_result_next;
    logic       nack_seen_reg, nack_seen_next;
    logic       scl_next, sda_next, busy_next, done_next;

    logic       advance;
    logic       cfg_write;
    logic       ack_go;
    logic [7:0] dev_w;
    i2cee_pkg::phase_t ph;

    // handshake
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;

    // apb access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[2])
            i2cee_pkg::REG_DEVICE_SELECT:  prdata = {25'd0, device_select_reg};
            i2cee_pkg::REG_ACK_POLL_LIMIT: prdata = {24'd0, ack_poll_limit_reg};
            default:                       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_select_reg  <= i2cee_pkg::DEVICE_SELECT_RESET;
            ack_poll_limit_reg <= i2cee_pkg::ACK_POLL_LIMIT_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                i2cee_pkg::REG_DEVICE_SELECT:  device_select_reg  <= pwdata[6:0];
                i2cee_pkg::REG_ACK_POLL_LIMIT: ack_poll_limit_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_op_reg   <= s_axis_tuser[1:0];
            in_addr_reg <= s_axis_tdata[7:0];
            in_data_reg <= s_axis_tdata[15:8];
            in_sda_reg  <= s_axis_tdata[16];
        end
    end

    assign dev_w = {device_select_reg, 1'b0};

    // one bus half-period of the transaction sequencer
    always_comb begin
        phase_next           = phase_reg;
        seq_step_next        = seq_step_reg;
        bit_index_next       = bit_index_reg;
        shift_byte_next      = shift_byte_reg;
        poll_count_next      = poll_count_reg;
        is_read_next         = is_read_reg;
        latched_address_next = latched_address_reg;
        latched_data_next    = latched_data_reg;
        read_result_next     = read_result_reg;
        nack_seen_next       = nack_seen_reg;
        scl_next             = 1'b1;
        sda_next             = 1'b1;
        busy_next            = 1'b1;
        done_next            = 1'b0;
        ack_go               = 1'b0;
        ph                   = phase_reg;

        // new request, taken only while idle
        if (phase_reg == i2cee_pkg::PH_IDLE &&
            (in_op_reg == i2cee_pkg::OP_WRITE || in_op_reg == i2cee_pkg::OP_READ)) begin
            is_read_next         = (in_op_reg == i2cee_pkg::OP_READ);
            latched_address_next = in_addr_reg;
            latched_data_next    = in_data_reg;
            nack_seen_next       = 1'b0;
            seq_step_next        = i2cee_pkg::SEQ_DEVICE;
            poll_count_next      = '0;
            bit_index_next       = '0;
            ph                   = i2cee_pkg::PH_START_A;
        end

        case (ph)
            i2cee_pkg::PH_START_A: begin
                phase_next = i2cee_pkg::PH_START_B;
            end
            i2cee_pkg::PH_START_B: begin
                sda_next   = 1'b0;
                phase_next = i2cee_pkg::PH_START_C;
            end
            i2cee_pkg::PH_START_C: begin
                scl_next        = 1'b0;
                sda_next        = 1'b0;
                shift_byte_next = (seq_step_reg == i2cee_pkg::SEQ_DEVICE) ? dev_w
                                                                          : (dev_w | 8'h01);
                bit_index_next  = '0;
                phase_next      = i2cee_pkg::PH_TX_LOW;
            end
            i2cee_pkg::PH_TX_LOW: begin
                scl_next   = 1'b0;
                sda_next   = shift_byte_reg[7];
                phase_next = i2cee_pkg::PH_TX_HIGH;
            end
            i2cee_pkg::PH_TX_HIGH: begin
                sda_next = shift_byte_reg[7];
                if (bit_index_reg == 3'd7) begin
                    poll_count_next = '0;
                    phase_next      = i2cee_pkg::PH_ACK_LOW;
                end else begin
                    bit_index_next  = bit_index_reg + 3'd1;
                    shift_byte_next = {shift_byte_reg[6:0], 1'b0};
                    phase_next      = i2cee_pkg::PH_TX_LOW;
                end
            end
            i2cee_pkg::PH_ACK_LOW: begin
                scl_next   = 1'b0;
                phase_next = i2cee_pkg::PH_ACK_POLL;
            end
            i2cee_pkg::PH_ACK_POLL: begin
                // slave acknowledge, or give up after the poll limit
                if (!in_sda_reg) begin
                    ack_go = 1'b1;
                end else if (poll_count_reg >= ack_poll_limit_reg) begin
                    nack_seen_next = 1'b1;
                    ack_go         = 1'b1;
                end else begin
                    poll_count_next = poll_count_reg + 8'd1;
                end
            end
            i2cee_pkg::PH_RESTART_LOW: begin
                scl_next   = 1'b0;
                phase_next = i2cee_pkg::PH_START_A;
            end
            i2cee_pkg::PH_RX_LOW: begin
                scl_next   = 1'b0;
                phase_next = i2cee_pkg::PH_RX_HIGH;
            end
            i2cee_pkg::PH_RX_HIGH: begin
                // sample while scl is high
                shift_byte_next = {shift_byte_reg[6:0], in_sda_reg};
                if (bit_index_reg == 3'd7) begin
                    phase_next = i2cee_pkg::PH_MNACK_LOW;
                end else begin
                    bit_index_next = bit_index_reg + 3'd1;
                    phase_next     = i2cee_pkg::PH_RX_LOW;
                end
            end
            i2cee_pkg::PH_MNACK_LOW: begin
                scl_next   = 1'b0;
                phase_next = i2cee_pkg::PH_MNACK_HIGH;
            end
            i2cee_pkg::PH_MNACK_HIGH: begin
                phase_next = i2cee_pkg::PH_STOP_A;
            end
            i2cee_pkg::PH_STOP_A: begin
                scl_next   = 1'b0;
                sda_next   = 1'b0;
                phase_next = i2cee_pkg::PH_STOP_B;
            end
            i2cee_pkg::PH_STOP_B: begin
                sda_next   = 1'b0;
                phase_next = i2cee_pkg::PH_STOP_C;
            end
            i2cee_pkg::PH_STOP_C: begin
                if (is_read_reg) begin
                    read_result_next = shift_byte_reg;
                end
                done_next  = 1'b1;
                busy_next  = 1'b0;
                phase_next = i2cee_pkg::PH_IDLE;
            end
            default: begin
                busy_next  = 1'b0;
                phase_next = i2cee_pkg::PH_IDLE;
            end
        endcase

        // pick the next byte once an acknowledge slot ends
        if (ack_go) begin
            case (seq_step_reg)
                i2cee_pkg::SEQ_DEVICE: begin
                    seq_step_next   = i2cee_pkg::SEQ_ADDRESS;
                    shift_byte_next = latched_address_reg;
                    bit_index_next  = '0;
                    phase_next      = i2cee_pkg::PH_TX_LOW;
                end
                i2cee_pkg::SEQ_ADDRESS: begin
                    seq_step_next = i2cee_pkg::SEQ_SECOND;
                    if (is_read_reg) begin
                        phase_next = i2cee_pkg::PH_RESTART_LOW;
                    end else begin
                        shift_byte_next = latched_data_reg;
                        bit_index_next  = '0;
                        phase_next      = i2cee_pkg::PH_TX_LOW;
                    end
                end
                i2cee_pkg::SEQ_SECOND: begin
                    if (is_read_reg) begin
                        seq_step_next   = i2cee_pkg::SEQ_RECEIVE;
                        shift_byte_next = '0;
                        bit_index_next  = '0;
                        phase_next      = i2cee_pkg::PH_RX_LOW;
                    end else begin
                        phase_next = i2cee_pkg::PH_STOP_A;
                    end
                end
                default: begin
                    phase_next = i2cee_pkg::PH_STOP_A;
                end
            endcase
        end
    end

    // transaction state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= i2cee_pkg::PH_IDLE;
            seq_step_reg        <= i2cee_pkg::SEQ_DEVICE;
            bit_index_reg       <= '0;
            shift_byte_reg      <= '0;
            poll_count_reg      <= '0;
            is_read_reg         <= 1'b0;
            latched_address_reg <= '0;
            latched_data_reg    <= '0;
            read_result_reg     <= '0;
            nack_seen_reg       <= 1'b0;
        end else if (advance) begin
            phase_reg           <= phase_next;
            seq_step_reg        <= seq_step_next;
            bit_index_reg       <= bit_index_next;
            shift_byte_reg      <= shift_byte_next;
            poll_count_reg      <= poll_count_next;
            is_read_reg         <= is_read_next;
            latched_address_reg <= latched_address_next;
            latched_data_reg    <= latched_data_next;
            read_result_reg     <= read_result_next;
            nack_seen_reg       <= nack_seen_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            scl_reg  <= scl_next;
            sda_reg  <= sda_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // read_result and nack_seen registers already hold the word's values
    assign m_axis_tdata = {3'd0, nack_seen_reg, read_result_reg,
                           done_reg, busy_reg, sda_reg, scl_reg};

endmodule

// File: rtl/core/i2cee_checker.sv
// i2cee_checker: port-level checks of the i2c eeprom byte master result stream
// depends on i2cee_pkg for the result word layout; bound to the top level below
module i2cee_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [i2cee_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    logic                            out_fire;
    logic                            prev_seen_reg;
    logic [i2cee_pkg::M_TDATA_W-1:0] prev_word_reg;
    logic                            cur_scl, cur_sda, cur_busy, cur_done, cur_nack;
    logic [7:0]                      cur_rdata, prev_rdata;
    logic                            prev_busy, prev_done;

    assign out_fire   = m_axis_tvalid && m_axis_tready;
    assign cur_scl    = m_axis_tdata[i2cee_pkg::M_SCL_BIT];
    assign cur_sda    = m_axis_tdata[i2cee_pkg::M_SDA_BIT];
    assign cur_busy   = m_axis_tdata[i2cee_pkg::M_BUSY_BIT];
    assign cur_done   = m_axis_tdata[i2cee_pkg::M_DONE_BIT];
    assign cur_nack   = m_axis_tdata[i2cee_pkg::M_NACK_BIT];
    assign cur_rdata  = m_axis_tdata[i2cee_pkg::M_RDATA_MSB:i2cee_pkg::M_RDATA_LSB];
    assign prev_rdata = prev_word_reg[i2cee_pkg::M_RDATA_MSB:i2cee_pkg::M_RDATA_LSB];
    assign prev_busy  = prev_word_reg[i2cee_pkg::M_BUSY_BIT];
    assign prev_done  = prev_word_reg[i2cee_pkg::M_DONE_BIT];

    // last delivered result word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_seen_reg <= 1'b0;
            prev_word_reg <= '0;
        end else if (out_fire) begin
            prev_seen_reg <= 1'b1;
            prev_word_reg <= m_axis_tdata;
        end
    end

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // the half-period after a stop leaves both lines released
    a_after_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        out_fire && prev_seen_reg && prev_done |-> cur_scl && cur_sda)
        else $error("bus not released after stop");

    // a transaction opens with both lines high and a cleared nack flag
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        out_fire && prev_seen_reg && !prev_busy && cur_busy |-> cur_scl && cur_sda && !cur_nack)
        else $error("bad start of transaction");

    // read data only changes on the word that completes the stop
    a_rdata: assert property (@(posedge aclk) disable iff (!aresetn)
        out_fire && prev_seen_reg && !cur_done |-> cur_rdata == prev_rdata)
        else $error("read data changed outside stop");

endmodule

bind i2c_eeprom_byte_master_unit i2cee_checker u_i2cee_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: dv/tb_i2c_eeprom_byte_master_unit.sv
`timescale 1ns / 1ps
// tb_i2c_eeprom_byte_master_unit: self-checking bench for the tick-driven i2c eeprom master
// predicts every result word from its own model of the bus sequencer and compares it
// depends on i2cee_pkg and rtl/core/i2c_eeprom_byte_master_unit.sv
module tb_i2c_eeprom_byte_master_unit;

    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam int unsigned STALL_LIMIT = 5000;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rdata;
        logic       nack;
    } bus_levels_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    // [7:0] word_address, [15:8] write_data, [16] sda_in, [23:17] zero
    logic [i2cee_pkg::S_TDATA_W-1:0]  s_axis_tdata = '0;
    // [1:0] operation
    logic [i2cee_pkg::S_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res,
    // [11:4] read_data, [12] ack_missing, [15:13] zero
    logic [i2cee_pkg::M_TDATA_W-1:0]  m_axis_tdata;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [i2cee_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [i2cee_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [i2cee_pkg::APB_DATA_W-1:0] prdata;
    logic                             pready;

    i2c_eeprom_byte_master_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 aclk = ~aclk;

    // predicted master state and register copies
    logic [6:0]  cfg_dev = i2cee_pkg::DEVICE_SELECT_RESET;
    logic [7:0]  cfg_limit = i2cee_pkg::ACK_POLL_LIMIT_RESET;
    i2cee_pkg::phase_t st_phase = i2cee_pkg::PH_IDLE;
    logic [2:0]  st_bit = '0;
    logic [7:0]  st_shift = '0;
    logic [7:0]  st_poll = '0;
    logic        st_is_read = 1'b0;
    logic [7:0]  st_addr = '0;
    logic [7:0]  st_data = '0;
    logic [7:0]  st_rdata = '0;
    logic        st_nack = 1'b0;
    logic        st_scl = 1'b1;
    logic        st_sda = 1'b1;
    logic [1:0]  st_seq = i2cee_pkg::SEQ_DEVICE;

    bus_levels_t bus_levels_q[$];

    // sender and receiver bookkeeping
    logic        valid_held = 1'b0;
    int          idle_gap = 1;
    int          burst_left = 0;
    int          rx_mode = 0;
    int          rx_mode_left = 0;
    int unsigned quiet_cycles = 0;
    int          mismatch_count = 0;
    int          word_count = 0;
    int          result_count = 0;
    int          write_count = 0;
    int          read_count = 0;
    int          nack_count = 0;

    function automatic void load_byte(input logic [7:0] b);
        st_shift = b;
        st_bit   = 3'd0;
        st_phase = i2cee_pkg::PH_TX_LOW;
    endfunction

    // next byte of the sequence once an acknowledge is taken or timed out
    function automatic void advance_after_ack();
        if (st_seq == i2cee_pkg::SEQ_DEVICE) begin
            st_seq = i2cee_pkg::SEQ_ADDRESS;
            load_byte(st_addr);
        end else if (st_seq == i2cee_pkg::SEQ_ADDRESS) begin
            st_seq = i2cee_pkg::SEQ_SECOND;
            if (st_is_read) begin
                st_phase = i2cee_pkg::PH_RESTART_LOW;
            end else begin
                load_byte(st_data);
            end
        end else if (st_seq == i2cee_pkg::SEQ_SECOND && st_is_read) begin
            st_seq   = i2cee_pkg::SEQ_RECEIVE;
            st_shift = 8'd0;
            st_bit   = 3'd0;
            st_phase = i2cee_pkg::PH_RX_LOW;
        end else begin
            st_phase = i2cee_pkg::PH_STOP_A;
        end
    endfunction

    // one bus half-period of the master: drive levels and status for this tick
    function automatic bus_levels_t predict_levels(input logic [1:0] op, input logic [7:0] addr,
                                                   input logic [7:0] data, input logic sda);
        bus_levels_t r;
        logic [7:0]  dev_w;
        dev_w  = {cfg_dev, 1'b0};
        r.busy = 1'b1;
        r.done = 1'b0;
        if (st_phase == i2cee_pkg::PH_IDLE &&
            (op == i2cee_pkg::OP_WRITE || op == i2cee_pkg::OP_READ)) begin
            st_is_read = (op == i2cee_pkg::OP_READ);
            st_addr    = addr;
            st_data    = data;
            st_nack    = 1'b0;
            st_seq     = i2cee_pkg::SEQ_DEVICE;
            st_poll    = 8'd0;
            st_bit     = 3'd0;
            st_phase   = i2cee_pkg::PH_START_A;
            if (op == i2cee_pkg::OP_READ) read_count++;
            else write_count++;
        end
        case (st_phase)
            i2cee_pkg::PH_START_A: begin
                {st_scl, st_sda} = 2'b11;
                st_phase = i2cee_pkg::PH_START_B;
            end
            i2cee_pkg::PH_START_B: begin
                {st_scl, st_sda} = 2'b10;
                st_phase = i2cee_pkg::PH_START_C;
            end
            i2cee_pkg::PH_START_C: begin
                {st_scl, st_sda} = 2'b00;
                load_byte(st_seq == i2cee_pkg::SEQ_DEVICE ? dev_w : (dev_w | 8'h01));
            end
            i2cee_pkg::PH_TX_LOW: begin
                {st_scl, st_sda} = {1'b0, st_shift[7]};
                st_phase = i2cee_pkg::PH_TX_HIGH;
            end
            i2cee_pkg::PH_TX_HIGH: begin
                {st_scl, st_sda} = {1'b1, st_shift[7]};
                if (st_bit == 3'd7) begin
                    st_poll  = 8'd0;
                    st_phase = i2cee_pkg::PH_ACK_LOW;
                end else begin
                    st_bit   = st_bit + 3'd1;
                    st_shift = st_shift << 1;
                    st_phase = i2cee_pkg::PH_TX_LOW;
                end
            end
            i2cee_pkg::PH_ACK_LOW: begin
                {st_scl, st_sda} = 2'b01;
                st_phase = i2cee_pkg::PH_ACK_POLL;
            end
            i2cee_pkg::PH_ACK_POLL: begin
                {st_scl, st_sda} = 2'b11;
                if (!sda) begin
                    advance_after_ack();
                end else if (st_poll >= cfg_limit) begin
                    st_nack = 1'b1;
                    nack_count++;
                    advance_after_ack();
                end else begin
                    st_poll = st_poll + 8'd1;
                end
            end
            i2cee_pkg::PH_RESTART_LOW: begin
                {st_scl, st_sda} = 2'b01;
                st_phase = i2cee_pkg::PH_START_A;
            end
            i2cee_pkg::PH_RX_LOW: begin
                {st_scl, st_sda} = 2'b01;
                st_phase = i2cee_pkg::PH_RX_HIGH;
            end
            i2cee_pkg::PH_RX_HIGH: begin
                {st_scl, st_sda} = 2'b11;
                st_shift = {st_shift[6:0], sda};
                if (st_bit == 3'd7) begin
                    st_phase = i2cee_pkg::PH_MNACK_LOW;
                end else begin
                    st_bit   = st_bit + 3'd1;
                    st_phase = i2cee_pkg::PH_RX_LOW;
                end
            end
            i2cee_pkg::PH_MNACK_LOW: begin
                {st_scl, st_sda} = 2'b01;
                st_phase = i2cee_pkg::PH_MNACK_HIGH;
            end
            i2cee_pkg::PH_MNACK_HIGH: begin
                {st_scl, st_sda} = 2'b11;
                st_phase = i2cee_pkg::PH_STOP_A;
            end
            i2cee_pkg::PH_STOP_A: begin
                {st_scl, st_sda} = 2'b00;
                st_phase = i2cee_pkg::PH_STOP_B;
            end
            i2cee_pkg::PH_STOP_B: begin
                {st_scl, st_sda} = 2'b10;
                st_phase = i2cee_pkg::PH_STOP_C;
            end
            i2cee_pkg::PH_STOP_C: begin
                {st_scl, st_sda} = 2'b11;
                if (st_is_read) st_rdata = st_shift;
                r.done   = 1'b1;
                r.busy   = 1'b0;
                st_phase = i2cee_pkg::PH_IDLE;
            end
            default: begin
                {st_scl, st_sda} = 2'b11;
                r.busy   = 1'b0;
                st_phase = i2cee_pkg::PH_IDLE;
            end
        endcase
        r.scl   = st_scl;
        r.sda   = st_sda;
        r.rdata = st_rdata;
        r.nack  = st_nack;
        return r;
    endfunction

    // send one word in bursts with random gaps, predict its result on acceptance
    task automatic send_bus_tick(input logic [1:0] op, input logic [7:0] addr,
                                 input logic [7:0] data, input logic sda);
        if (!valid_held) repeat (idle_gap) @(posedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, sda, data, addr};
        s_axis_tuser  <= op;
        valid_held = 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        bus_levels_q.push_back(predict_levels(op, addr, data, sda));
        word_count++;
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            valid_held = 1'b0;
            idle_gap   = $urandom_range(1, 6);
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 16);
        end else begin
            burst_left--;
        end
    endtask

    // one tick whose content suits the current phase
    task automatic random_tick(input int ack_ok_pct);
        logic [1:0] op;
        logic       sda;
        int         pick;
        pick = $urandom_range(0, 99);
        if (st_phase == i2cee_pkg::PH_IDLE) begin
            op = pick < 35 ? i2cee_pkg::OP_WRITE :
                 pick < 70 ? i2cee_pkg::OP_READ  :
                 pick < 85 ? i2cee_pkg::OP_TICK  : OP_RESERVED;
        end else begin
            op = pick < 75 ? i2cee_pkg::OP_TICK : 2'($urandom_range(0, 3));
        end
        if (st_phase == i2cee_pkg::PH_ACK_POLL) begin
            sda = ($urandom_range(0, 99) < ack_ok_pct) ? 1'b0 : 1'b1;
        end else begin
            sda = 1'($urandom_range(0, 1));
        end
        send_bus_tick(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), sda);
    endtask

    task automatic run_to_idle(input int ack_ok_pct);
        while (st_phase != i2cee_pkg::PH_IDLE) random_tick(ack_ok_pct);
    endtask

    // hold the sender until every predicted word has come back
    task automatic drain_results();
        if (valid_held) begin
            s_axis_tvalid <= 1'b0;
            valid_held = 1'b0;
            idle_gap   = 1;
        end
        while (bus_levels_q.size() != 0) @(posedge aclk);
    endtask

    task automatic settle_master();
        run_to_idle(100);
        drain_results();
        repeat (4) @(posedge aclk);
    endtask

    // register write then read-back, only with the master idle and drained
    task automatic program_register(input logic reg_idx, input int unsigned value);
        logic [i2cee_pkg::APB_DATA_W-1:0] want;
        settle_master();
        want = (reg_idx == i2cee_pkg::REG_DEVICE_SELECT) ? (value & 32'h7f) : (value & 32'hff);
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_idx == i2cee_pkg::REG_DEVICE_SELECT) cfg_dev = want[6:0];
        else cfg_limit = want[7:0];
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== want) begin
            $error("register %0d readback expected %0h got %0h", reg_idx, want, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // result checker, receiver stall pattern and watchdog
    always @(posedge aclk) begin
        bus_levels_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            result_count++;
            if (bus_levels_q.size() == 0) begin
                $error("result word %0h arrived with nothing expected", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = bus_levels_q.pop_front();
                if (m_axis_tdata[i2cee_pkg::M_SCL_BIT] !== want.scl) begin
                    $error("scl_out expected %0d got %0d", want.scl,
                           m_axis_tdata[i2cee_pkg::M_SCL_BIT]);
                    mismatch_count++;
                end
                if (m_axis_tdata[i2cee_pkg::M_SDA_BIT] !== want.sda) begin
                    $error("sda_out expected %0d got %0d", want.sda,
                           m_axis_tdata[i2cee_pkg::M_SDA_BIT]);
                    mismatch_count++;
                end
                if (m_axis_tdata[i2cee_pkg::M_BUSY_BIT] !== want.busy) begin
                    $error("busy_res expected %0d got %0d", want.busy,
                           m_axis_tdata[i2cee_pkg::M_BUSY_BIT]);
                    mismatch_count++;
                end
                if (m_axis_tdata[i2cee_pkg::M_DONE_BIT] !== want.done) begin
                    $error("done_res expected %0d got %0d", want.done,
                           m_axis_tdata[i2cee_pkg::M_DONE_BIT]);
                    mismatch_count++;
                end
                if (m_axis_tdata[i2cee_pkg::M_RDATA_MSB:i2cee_pkg::M_RDATA_LSB] !== want.rdata)
                begin
                    $error("read_data expected %0h got %0h", want.rdata,
                           m_axis_tdata[i2cee_pkg::M_RDATA_MSB:i2cee_pkg::M_RDATA_LSB]);
                    mismatch_count++;
                end
                if (m_axis_tdata[i2cee_pkg::M_NACK_BIT] !== want.nack) begin
                    $error("ack_missing expected %0d got %0d", want.nack,
                           m_axis_tdata[i2cee_pkg::M_NACK_BIT]);
                    mismatch_count++;
                end
            end
        end
        // stall modes: always ready, light stalls, heavy stalls
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(20, 200);
        end else begin
            rx_mode_left--;
        end
        m_axis_tready <= (rx_mode == 0) ? 1'b1 :
                         (rx_mode == 1) ? ($urandom_range(0, 3) != 0) : 1'($urandom_range(0, 1));
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // idle ticks and the reserved operation code
    task automatic test_idle_ticks();
        send_bus_tick(i2cee_pkg::OP_TICK, 8'h00, 8'h00, 1'b0);
        send_bus_tick(i2cee_pkg::OP_TICK, 8'hff, 8'hff, 1'b1);
        send_bus_tick(OP_RESERVED, 8'hff, 8'hff, 1'b1);
        send_bus_tick(OP_RESERVED, 8'h00, 8'h00, 1'b0);
    endtask

    // write with field extremes and requests arriving while busy
    task automatic test_byte_write();
        program_register(i2cee_pkg::REG_DEVICE_SELECT, 127);
        program_register(i2cee_pkg::REG_ACK_POLL_LIMIT, 3);
        send_bus_tick(i2cee_pkg::OP_WRITE, 8'hff, 8'h00, 1'b1);
        send_bus_tick(i2cee_pkg::OP_READ, 8'h00, 8'hff, 1'b0);
        send_bus_tick(i2cee_pkg::OP_WRITE, 8'h5a, 8'ha5, 1'b1);
        send_bus_tick(OP_RESERVED, 8'h00, 8'h00, 1'b0);
        run_to_idle(100);
        send_bus_tick(i2cee_pkg::OP_WRITE, 8'h00, 8'hff, 1'b0);
        run_to_idle(100);
    endtask

    // read with a repeated start, random bits shifted in
    task automatic test_byte_read();
        program_register(i2cee_pkg::REG_DEVICE_SELECT, 0);
        send_bus_tick(i2cee_pkg::OP_READ, 8'h00, 8'hff, 1'b0);
        run_to_idle(100);
        send_bus_tick(i2cee_pkg::OP_READ, 8'hff, 8'h00, 1'b1);
        run_to_idle(80);
    endtask

    // acknowledge timeouts at a short and a zero poll limit, then a new request clears the flag
    task automatic test_ack_timeout();
        program_register(i2cee_pkg::REG_DEVICE_SELECT, 32'(i2cee_pkg::DEVICE_SELECT_RESET));
        program_register(i2cee_pkg::REG_ACK_POLL_LIMIT, 6);
        send_bus_tick(i2cee_pkg::OP_WRITE, 8'h3c, 8'hc3, 1'b1);
        while (!st_nack) send_bus_tick(i2cee_pkg::OP_TICK, 8'h00, 8'h00, 1'b1);
        run_to_idle(100);
        program_register(i2cee_pkg::REG_ACK_POLL_LIMIT, 0);
        send_bus_tick(i2cee_pkg::OP_READ, 8'h81, 8'h18, 1'b1);
        run_to_idle(0);
        send_bus_tick(i2cee_pkg::OP_WRITE, 8'h7e, 8'he7, 1'b0);
        run_to_idle(100);
    endtask

    // random traffic over several register settings
    task automatic test_random_traffic();
        int ack_ok;
        for (int p = 0; p < 4; p++) begin
            program_register(i2cee_pkg::REG_DEVICE_SELECT, $urandom_range(0, 127));
            program_register(i2cee_pkg::REG_ACK_POLL_LIMIT,
                             (p == 3) ? 255 : $urandom_range(0, 5));
            ack_ok = (p == 3) ? 95 : $urandom_range(50, 90);
            for (int k = 0; k < 35; k++) begin
                random_tick(ack_ok);
                if (p == 1 && k == 15) drain_results();
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_ticks();
        test_byte_write();
        test_byte_read();
        test_ack_timeout();
        test_random_traffic();
        settle_master();
        $display("covered %0d words, %0d results: %0d writes, %0d reads, %0d ack timeouts",
                 word_count, result_count, write_count, read_count, nack_count);
        $display("device select and poll limit swept through extremes and random values");
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
